@@ design/acc8_pkg.sv @@
// Shared types, codes and the microcode table of the accumulator CPU.
package acc8_pkg;

	typedef enum logic [1:0] {
		CMD_WR = 2'd0,
		CMD_RD = 2'd1,
		CMD_EX = 2'd2
	} cmd_t;

	localparam logic [7:0] OP_NOP = 8'd0;
	localparam logic [7:0] OP_STA = 8'd16;
	localparam logic [7:0] OP_LDA = 8'd32;
	localparam logic [7:0] OP_ADD = 8'd48;
	localparam logic [7:0] OP_OR  = 8'd64;
	localparam logic [7:0] OP_AND = 8'd80;
	localparam logic [7:0] OP_NOT = 8'd96;
	localparam logic [7:0] OP_JMP = 8'd128;
	localparam logic [7:0] OP_JN  = 8'd144;
	localparam logic [7:0] OP_JZ  = 8'd160;
	localparam logic [7:0] OP_HLT = 8'd240;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_DISP = 3'd1,
		ST_RDWR = 3'd2,
		ST_FOP  = 3'd3,
		ST_FARG = 3'd4,
		ST_FVAL = 3'd5,
		ST_EXEC = 3'd6
	} step_t;

	// memory address source
	typedef enum logic [2:0] {
		AM_IN    = 3'd0,
		AM_PC    = 3'd1,
		AM_PC1   = 3'd2,
		AM_RDATA = 3'd3,
		AM_ARG   = 3'd4
	} amux_t;

	typedef enum logic [1:0] {
		JC_NEVER  = 2'd0,
		JC_ALWAYS = 2'd1,
		JC_NOACC  = 2'd2,
		JC_EX     = 2'd3
	} jc_t;

	typedef struct packed {
		logic  ready;
		amux_t amux;
		logic  we_in;
		logic  ld_ir;
		logic  ld_arg;
		logic  ld_rd;
		logic  exec;
		logic  emit;
		jc_t   jc;
		step_t target;
	} ucw_t;

	typedef struct packed {
		logic in_valid;
		logic out_busy;
		logic cmd_ex;
	} seq_stat_t;

	typedef struct packed {
		logic       bad_opcode;
		logic       halted;
		logic       zero_flag;
		logic       neg_flag;
		logic [7:0] accum;
		logic [7:0] prog_counter;
		logic [7:0] rd_data;
	} res_t;

	function automatic ucw_t ucode(step_t s);
		ucw_t w;
		w = '{ready: 1'b0, amux: AM_IN, we_in: 1'b0, ld_ir: 1'b0, ld_arg: 1'b0,
			ld_rd: 1'b0, exec: 1'b0, emit: 1'b0, jc: JC_NEVER, target: ST_IDLE};
		case (s)
			ST_IDLE: begin
				w.ready  = 1'b1;
				w.jc     = JC_NOACC;
				w.target = ST_IDLE;
			end
			ST_DISP: begin
				w.amux   = AM_IN;
				w.we_in  = 1'b1;
				w.jc     = JC_EX;
				w.target = ST_FOP;
			end
			ST_RDWR: begin
				w.amux   = AM_IN;
				w.ld_rd  = 1'b1;
				w.emit   = 1'b1;
				w.jc     = JC_ALWAYS;
				w.target = ST_IDLE;
			end
			ST_FOP: begin
				w.amux = AM_PC;
			end
			ST_FARG: begin
				w.amux  = AM_PC1;
				w.ld_ir = 1'b1;
			end
			ST_FVAL: begin
				w.amux   = AM_RDATA;
				w.ld_arg = 1'b1;
			end
			ST_EXEC: begin
				w.amux   = AM_ARG;
				w.exec   = 1'b1;
				w.emit   = 1'b1;
				w.jc     = JC_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

@@ design/acc8_ram.sv @@
// 256 x 8 single-port main memory with registered read.
module acc8_ram (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] addr,
	input  logic [7:0] wdata,
	output logic [7:0] rdata
);
	logic [7:0] mem_q [256];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/acc8_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jumps.
module acc8_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acc8_pkg::seq_stat_t  stat,
	output acc8_pkg::ucw_t       ctl,
	output logic                 go
);
	import acc8_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl = ucode(step_q);
		// hold the emitting step while the result register is still full
		go  = !(ctl.emit && stat.out_busy);
		case (ctl.jc)
			JC_ALWAYS: take = 1'b1;
			JC_NOACC:  take = !stat.in_valid;
			JC_EX:     take = stat.cmd_ex;
			default:   take = 1'b0;
		endcase
		if (!go) begin
			step_d = step_q;
		end else if (take) begin
			step_d = ctl.target;
		end else begin
			step_d = step_t'(3'(step_q + 3'd1));
		end
	end

`ifndef SYNTHESIS
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.ready && stat.in_valid) |=> step_q == ST_DISP)
		else $error("accepted beat did not advance to dispatch");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && go) |=> step_q == ST_IDLE)
		else $error("emitted result without returning to idle");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(step_q))
		else $error("step moved during output stall");
`endif
endmodule

@@ design/acc8_dp.sv @@
// Datapath: command latch, PC, AC, flags, instruction and operand registers.
module acc8_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [1:0]      in_cmd,
	input  logic [7:0]      in_addr,
	input  logic [7:0]      in_wdata,
	input  acc8_pkg::ucw_t  ctl,
	input  logic            go,
	input  logic [7:0]      rdata,
	output logic            ram_we,
	output logic [7:0]      ram_addr,
	output logic [7:0]      ram_wdata,
	output logic            cmd_ex,
	output acc8_pkg::res_t  res
);
	import acc8_pkg::*;

	cmd_t       cmd_q;
	logic [7:0] addr_q;
	logic [7:0] wdata_q;
	logic [7:0] ir_q;
	logic [7:0] arg_q;
	logic [7:0] pc_q;
	logic [7:0] ac_q;
	logic       n_q;
	logic       z_q;

	logic [7:0] pc_d;
	logic [7:0] ac_d;
	logic       n_d;
	logic       z_d;
	logic       upd_flags;
	logic       is_sta;
	logic       halt;
	logic       bad;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(in_cmd);
			addr_q  <= in_addr;
			wdata_q <= in_wdata;
		end
		if (go && ctl.ld_ir) begin
			ir_q <= rdata;
		end
		if (go && ctl.ld_arg) begin
			arg_q <= rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			ac_q <= '0;
			n_q  <= 1'b0;
			z_q  <= 1'b0;
		end else if (go && ctl.exec) begin
			pc_q <= pc_d;
			ac_q <= ac_d;
			n_q  <= n_d;
			z_q  <= z_d;
		end
	end

	// instruction execute; rdata holds the operand value in the execute step
	always_comb begin
		pc_d      = pc_q;
		ac_d      = ac_q;
		upd_flags = 1'b0;
		is_sta    = 1'b0;
		halt      = 1'b0;
		bad       = 1'b0;
		if (ctl.exec) begin
			case (ir_q)
				OP_NOP: pc_d = pc_q + 8'd1;
				OP_STA: begin
					is_sta = 1'b1;
					pc_d   = pc_q + 8'd2;
				end
				OP_LDA: begin
					ac_d      = rdata;
					upd_flags = 1'b1;
					pc_d      = pc_q + 8'd2;
				end
				OP_ADD: begin
					ac_d      = ac_q + rdata;
					upd_flags = 1'b1;
					pc_d      = pc_q + 8'd2;
				end
				OP_OR: begin
					ac_d      = ac_q | rdata;
					upd_flags = 1'b1;
					pc_d      = pc_q + 8'd2;
				end
				OP_AND: begin
					ac_d      = ac_q & rdata;
					upd_flags = 1'b1;
					pc_d      = pc_q + 8'd2;
				end
				OP_NOT: begin
					ac_d      = ~ac_q;
					upd_flags = 1'b1;
					pc_d      = pc_q + 8'd1;
				end
				OP_JMP: pc_d = arg_q;
				OP_JN:  pc_d = n_q ? arg_q : pc_q + 8'd2;
				OP_JZ:  pc_d = z_q ? arg_q : pc_q + 8'd2;
				OP_HLT: halt = 1'b1;
				default: bad = 1'b1;
			endcase
		end
		n_d = upd_flags ? ac_d[7] : n_q;
		z_d = upd_flags ? (ac_d == 8'd0) : z_q;
	end

	always_comb begin
		case (ctl.amux)
			AM_IN:    ram_addr = addr_q;
			AM_PC:    ram_addr = pc_q;
			AM_PC1:   ram_addr = pc_q + 8'd1;
			AM_RDATA: ram_addr = rdata;
			AM_ARG:   ram_addr = arg_q;
			default:  ram_addr = addr_q;
		endcase
		ram_wdata = ctl.exec ? ac_q : wdata_q;
		ram_we    = go && ((ctl.we_in && cmd_q == CMD_WR) || is_sta);
	end

	assign cmd_ex = (cmd_q == CMD_EX);

	always_comb begin
		res.rd_data      = (ctl.ld_rd && cmd_q == CMD_RD) ? rdata : 8'd0;
		res.prog_counter = pc_d;
		res.accum        = ac_d;
		res.neg_flag     = n_d;
		res.zero_flag    = z_d;
		res.halted       = halt;
		res.bad_opcode   = bad;
	end
endmodule

@@ design/accumulator_cpu_8bit.sv @@
// Top level of the 8-bit accumulator CPU.
// An 8-bit accumulator machine with 256 bytes of memory, driven by a
// microcoded sequencer over a single-port memory with registered read. Each
// input beat writes a memory byte, reads one back or executes one
// instruction at the PC, and yields exactly one result beat. Write, read
// and the unused command pass through the accept, dispatch and read/write
// steps; an execute passes through the accept and dispatch steps, then the
// three dependent memory reads (opcode, operand byte, operand value) through
// the one memory port, then the execute step.
// A new beat is accepted in the cycle after the previous result is
// registered, while that result may still wait for the consumer.
module accumulator_cpu_8bit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cmd[1:0], addr[9:2], wdata[17:10], zero pad
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rd_data[7:0], prog_counter[15:8], accum[23:16], neg_flag[24],
	// zero_flag[25], halted[26], bad_opcode[27], zero pad
	output logic [31:0] m_axis_tdata
);
	import acc8_pkg::*;

	ucw_t      ctl;
	seq_stat_t stat;
	res_t      res;
	logic      go;
	logic      accept;
	logic      cmd_ex;
	logic      ram_we;
	logic [7:0] ram_addr;
	logic [7:0] ram_wdata;
	logic [7:0] ram_rdata;
	logic      out_valid_q;
	res_t      out_data_q;

	assign s_axis_tready = ctl.ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign stat.in_valid = s_axis_tvalid;
	assign stat.out_busy = out_valid_q && !m_axis_tready;
	assign stat.cmd_ex   = cmd_ex;

	acc8_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.go     (go)
	);

	acc8_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_cmd    (s_axis_tdata[1:0]),
		.in_addr   (s_axis_tdata[9:2]),
		.in_wdata  (s_axis_tdata[17:10]),
		.ctl       (ctl),
		.go        (go),
		.rdata     (ram_rdata),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.cmd_ex    (cmd_ex),
		.res       (res)
	);

	acc8_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit && go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit && go) begin
			out_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_data_q};
endmodule

@@ verif/tb_accumulator_cpu_8bit.sv @@
// Self-checking testbench for the 8-bit accumulator CPU: directed program, random programs.
`timescale 1ns / 100ps

module tb_accumulator_cpu_8bit;
	import acc8_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int ITEM_COUNT = 1450;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	// Shadow of the CPU state; holds the results still owed by the block.
	class acc_cpu_shadow;
		logic [7:0] mem [256];
		logic [7:0] pc;
		logic [7:0] acc;
		logic       nf;
		logic       zf;
		res_t       owed_results [$];
		int         fails;

		function new();
			pc = 8'd0;
			acc = 8'd0;
			nf = 1'b0;
			zf = 1'b0;
			fails = 0;
		endfunction

		function void apply_command(logic [1:0] cmd, logic [7:0] addr, logic [7:0] wdata);
			res_t r;
			logic [7:0] nxt;
			logic [7:0] op;
			logic [7:0] arg;
			logic [7:0] val;
			logic upd;
			r = '0;
			upd = 1'b0;
			case (cmd)
				CMD_WR: mem[addr] = wdata;
				CMD_RD: r.rd_data = mem[addr];
				CMD_EX: begin
					nxt = pc + 8'd1;
					op = mem[pc];
					arg = mem[nxt];
					val = mem[arg];
					case (op)
						OP_NOP: pc = nxt;
						OP_STA: begin
							mem[arg] = acc;
							pc = pc + 8'd2;
						end
						OP_LDA: begin
							acc = val;
							pc = pc + 8'd2;
							upd = 1'b1;
						end
						OP_ADD: begin
							acc = acc + val;
							pc = pc + 8'd2;
							upd = 1'b1;
						end
						OP_OR: begin
							acc = acc | val;
							pc = pc + 8'd2;
							upd = 1'b1;
						end
						OP_AND: begin
							acc = acc & val;
							pc = pc + 8'd2;
							upd = 1'b1;
						end
						OP_NOT: begin
							acc = ~acc;
							pc = nxt;
							upd = 1'b1;
						end
						OP_JMP: pc = arg;
						OP_JN: pc = nf ? arg : pc + 8'd2;
						OP_JZ: pc = zf ? arg : pc + 8'd2;
						OP_HLT: r.halted = 1'b1;
						default: r.bad_opcode = 1'b1;
					endcase
				end
				default: ;
			endcase
			if (upd) begin
				nf = acc[7];
				zf = (acc == 8'd0);
			end
			r.prog_counter = pc;
			r.accum = acc;
			r.neg_flag = nf;
			r.zero_flag = zf;
			owed_results.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			fails++;
		endtask

		task check_result(logic [31:0] beat);
			res_t got;
			res_t want;
			got = beat[27:0];
			if (owed_results.size() == 0) begin
				report($sformatf("result beat %h with nothing owed", beat));
				return;
			end
			want = owed_results.pop_front();
			if (got.rd_data !== want.rd_data)
				report($sformatf("rd_data got %h want %h", got.rd_data, want.rd_data));
			if (got.prog_counter !== want.prog_counter)
				report($sformatf("prog_counter got %h want %h", got.prog_counter,
					want.prog_counter));
			if (got.accum !== want.accum)
				report($sformatf("accum got %h want %h", got.accum, want.accum));
			if (got.neg_flag !== want.neg_flag)
				report($sformatf("neg_flag got %b want %b", got.neg_flag, want.neg_flag));
			if (got.zero_flag !== want.zero_flag)
				report($sformatf("zero_flag got %b want %b", got.zero_flag, want.zero_flag));
			if (got.halted !== want.halted)
				report($sformatf("halted got %b want %b", got.halted, want.halted));
			if (got.bad_opcode !== want.bad_opcode)
				report($sformatf("bad_opcode got %b want %b", got.bad_opcode, want.bad_opcode));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	acc_cpu_shadow shadow;
	int idle_pct = 11;
	int n_items = 0;
	bit held = 1'b0;
	int stuck = 0;

	accumulator_cpu_8bit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	task offer_beat(input logic [1:0] cmd, input logic [7:0] addr, input logic [7:0] wdata);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, wdata, addr, cmd};
		do @(posedge clk); while (!s_axis_tready);
		shadow.apply_command(cmd, addr, wdata);
		if (cmd != CMD_NONE)
			n_items++;
	endtask

	// receiver: random backpressure, plus one long hold once the run is well under way
	initial begin
		forever begin
			@(negedge clk);
			if (!held && n_items >= 900) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			shadow.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] p;
		logic [7:0] op;
		logic [7:0] arg;
		logic [7:0] val;
		int sel;
		shadow = new();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// load the whole memory; the low pages carry a program that walks every opcode
		for (int i = 0; i < 256; i++) begin
			a = i[7:0];
			b = 8'($urandom);
			case (a)
				8'h00: b = OP_LDA;
				8'h01: b = 8'h80;
				8'h02: b = OP_JN;
				8'h03: b = 8'h06;
				8'h04: b = OP_HLT;
				8'h06: b = OP_ADD;
				8'h07: b = 8'h81;
				8'h08: b = OP_JZ;
				8'h09: b = 8'h0C;
				8'h0A: b = OP_HLT;
				8'h0C: b = OP_NOT;
				8'h0D: b = OP_OR;
				8'h0E: b = 8'h82;
				8'h0F: b = OP_AND;
				8'h10: b = 8'h83;
				8'h11: b = OP_STA;
				8'h12: b = 8'h85;
				8'h13: b = OP_JN;
				8'h14: b = 8'h00;
				8'h15: b = OP_JZ;
				8'h16: b = 8'h00;
				8'h17: b = OP_NOP;
				8'h18: b = OP_JMP;
				8'h19: b = 8'hFD;
				8'h20: b = 8'h01;
				8'h80: b = 8'h80;
				8'h81: b = 8'h80;
				8'h82: b = 8'h00;
				8'h83: b = 8'h7F;
				8'h84: b = 8'h7F;
				8'hFD: b = OP_LDA;
				8'hFE: b = 8'h84;
				8'hFF: b = OP_HLT;
				default: ;
			endcase
			offer_beat(CMD_WR, a, b);
		end

		// taken and untaken branches, ADD wrapping to zero, jump to the top of memory
		repeat (13) offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
		// halt keeps the PC
		repeat (2) offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
		// operand byte fetched across the wrap at 256
		offer_beat(CMD_WR, 8'hFF, OP_ADD);
		offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
		// unknown opcode leaves everything alone
		offer_beat(CMD_WR, 8'h01, 8'hF1);
		repeat (2) offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
		offer_beat(CMD_RD, 8'h85, 8'($urandom));
		offer_beat(CMD_RD, 8'h00, 8'($urandom));
		offer_beat(CMD_RD, 8'hFF, 8'($urandom));
		offer_beat(CMD_NONE, 8'hFF, 8'hFF);

		while (n_items < ITEM_COUNT) begin
			idle_pct = (n_items >= 500 && n_items < 700) ? 0 : 11;
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				// lay one instruction at the PC, then step it
				p = shadow.pc;
				case ($urandom_range(0, 11))
					0: op = OP_NOP;
					1: op = OP_STA;
					2: op = OP_LDA;
					3: op = OP_ADD;
					4: op = OP_OR;
					5: op = OP_AND;
					6: op = OP_NOT;
					7: op = OP_JMP;
					8: op = OP_JN;
					9: op = OP_JZ;
					10: op = OP_HLT;
					default: op = 8'($urandom);
				endcase
				arg = 8'($urandom);
				val = 8'($urandom);
				if ($urandom_range(0, 3) == 0)
					val = {8{val[0]}} ^ {val[1], 7'd0};
				if ((op == OP_LDA || op == OP_ADD || op == OP_OR || op == OP_AND) &&
						$urandom_range(0, 1))
					offer_beat(CMD_WR, arg, val);
				offer_beat(CMD_WR, p + 8'd1, arg);
				offer_beat(CMD_WR, p, op);
				offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
				if ($urandom_range(0, 9) < 3)
					repeat ($urandom_range(1, 4))
						offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
			end else if (sel < 72) begin
				repeat ($urandom_range(1, 3)) offer_beat(CMD_EX, 8'($urandom), 8'($urandom));
			end else if (sel < 85) begin
				offer_beat(CMD_RD, 8'($urandom), 8'($urandom));
			end else if (sel < 95) begin
				offer_beat(CMD_WR, 8'($urandom), 8'($urandom));
			end else begin
				offer_beat(CMD_NONE, 8'($urandom), 8'($urandom));
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (shadow.owed_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (shadow.fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
